// ----- rtl/core/bpdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared types and constants for the Bezier point evaluator: beat formats,
// operation codes, fixed-point widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package bpdc_pkg;

    // Fixed-point layout: coordinates Q16.16, parameter t unsigned Q1.16
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int CFG_W     = 4;
    localparam int IDX_W     = 3;

    // t of exactly 1.0
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Reset value of the point count register
    localparam logic [CFG_W-1:0] POINT_COUNT_RST = CFG_W'(4);

    typedef struct packed {
        logic                       operation;
        logic [IDX_W-1:0]           point_index;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic [T_W-1:0]             t_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0]  curve_x;
        logic signed [COORD_W-1:0]  curve_y;
    } t_out_beat;

    // Control shared by every cell of the row
    typedef struct packed {
        logic load;   // copy the stored control point into the work point
        logic mul;    // form t * (next - own) for this round
        logic acc;    // add the scaled difference to the work point
    } t_cell_ctrl;

endpackage

// ----- rtl/core/bezier_point_de_casteljau_core.sv -----
// ----------------------------------------------------------------------------
// bezier_point_de_casteljau_core
// 2-D Bezier curve point evaluator using de Casteljau interpolation over a
// row of cells, one control point per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_data) carries two kinds of
//   beat. A write beat stores one control point at point_index and gives
//   no result. An evaluate beat loads all cells from the stored points and
//   runs n-1 rounds of interpolation, n the point count clamped to
//   1 .. MAX_POINTS. Each round is a multiply step, then an accumulate step,
//   in every cell at once. Input ready returns the cycle after the result
//   loads, so a new evaluate beat is taken only once the last is through;
//   writes are taken every cycle while idle.
//   Output channel (o_out_valid / i_out_ready, o_out_data) has a result
//   register; a new beat is taken while a result still waits there. A
//   finished result holds in the row until the register frees up.
//   i_cfg_we / i_cfg_data write point_count; write it only while idle.
//   Reset (synchronous, active low) clears the stored points to zero, sets
//   point_count to 4 and empties the result register.
// ----------------------------------------------------------------------------
module bezier_point_de_casteljau_core #(
    parameter int MAX_POINTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bpdc_pkg::t_in_beat                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bpdc_pkg::t_out_beat                o_out_data,
    input  logic                               i_cfg_we,
    input  logic [bpdc_pkg::CFG_W-1:0]         i_cfg_data
);
    import bpdc_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ACC  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_rounds, n_rounds;
    logic [T_W-1:0]    r_t;
    logic [CFG_W-1:0]  r_point_count;
    logic              r_out_valid;
    t_out_beat         r_out_data;

    logic              w_in_acc;
    logic              w_eval_acc;
    logic [CNT_W-1:0]  w_count;
    logic              w_out_load;
    t_cell_ctrl        w_ctrl;

    logic signed [COORD_W-1:0] w_work_x [MAX_POINTS];
    logic signed [COORD_W-1:0] w_work_y [MAX_POINTS];

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_eval_acc = w_in_acc && (i_in_data.operation == OP_EVAL);

    // Clamp the point count to 1 .. MAX_POINTS
    always_comb begin
        if (r_point_count == '0) begin
            w_count = CNT_W'(1);
        end else if (int'(r_point_count) > MAX_POINTS) begin
            w_count = CNT_W'(MAX_POINTS);
        end else begin
            w_count = CNT_W'(r_point_count);
        end
    end

    // Point count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RST;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    // Latch t, saturated to 1.0
    always_ff @(posedge i_clk) begin
        if (w_eval_acc) begin
            r_t <= (i_in_data.t_value > T_ONE) ? T_ONE : i_in_data.t_value;
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_rounds = r_rounds;
        unique case (r_state)
            S_IDLE: begin
                if (w_eval_acc) begin
                    n_rounds = w_count - CNT_W'(1);
                    n_state  = (w_count == CNT_W'(1)) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_rounds = r_rounds - CNT_W'(1);
                n_state  = (r_rounds == CNT_W'(1)) ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rounds <= '0;
        end else begin
            r_state  <= n_state;
            r_rounds <= n_rounds;
        end
    end

    assign w_ctrl.load = w_eval_acc;
    assign w_ctrl.mul  = (r_state == S_MUL);
    assign w_ctrl.acc  = (r_state == S_ACC);

    // Row of cells; the last cell sees itself as neighbor
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        logic signed [COORD_W-1:0] w_next_x, w_next_y;
        logic                      w_wr;

        if (g == MAX_POINTS - 1) begin : g_last
            assign w_next_x = w_work_x[g];
            assign w_next_y = w_work_y[g];
        end else begin : g_mid
            assign w_next_x = w_work_x[g+1];
            assign w_next_y = w_work_y[g+1];
        end

        assign w_wr = w_in_acc && (i_in_data.operation == OP_WRITE)
                      && (int'(i_in_data.point_index) == g);

        bpdc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_wr     (w_wr),
            .i_wr_x   (i_in_data.point_x),
            .i_wr_y   (i_in_data.point_y),
            .i_t      (r_t),
            .i_next_x (w_next_x),
            .i_next_y (w_next_y),
            .o_work_x (w_work_x[g]),
            .o_work_y (w_work_y[g])
        );
    end

    // Result register: load when done and free, drop on accept
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data.curve_x <= w_work_x[0];
            r_out_data.curve_y <= w_work_y[0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/bpdc_cell.sv -----
// ----------------------------------------------------------------------------
// bpdc_cell
// One cell of the interpolation row. Holds one control point and one work
// point, and per round replaces its work point with the lerp toward the work
// point of its right-hand neighbor.
// ----------------------------------------------------------------------------
module bpdc_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bpdc_pkg::t_cell_ctrl                   i_ctrl,
    input  logic                                   i_wr,
    input  logic signed [bpdc_pkg::COORD_W-1:0]    i_wr_x,
    input  logic signed [bpdc_pkg::COORD_W-1:0]    i_wr_y,
    input  logic [bpdc_pkg::T_W-1:0]               i_t,
    input  logic signed [bpdc_pkg::COORD_W-1:0]    i_next_x,
    input  logic signed [bpdc_pkg::COORD_W-1:0]    i_next_y,
    output logic signed [bpdc_pkg::COORD_W-1:0]    o_work_x,
    output logic signed [bpdc_pkg::COORD_W-1:0]    o_work_y
);
    import bpdc_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;

    logic signed [COORD_W-1:0] r_ctrl_x, r_ctrl_y;
    logic signed [COORD_W-1:0] r_work_x, r_work_y;
    logic signed [COORD_W-1:0] r_prod_x, r_prod_y;

    logic signed [DIFF_W-1:0]  w_diff_x, w_diff_y;
    logic signed [T_W:0]       w_t_s;
    logic signed [PROD_W-1:0]  w_prod_x, w_prod_y;

    // Exact difference and product; the floored shift is a bit-select
    assign w_diff_x = {i_next_x[COORD_W-1], i_next_x} - {r_work_x[COORD_W-1], r_work_x};
    assign w_diff_y = {i_next_y[COORD_W-1], i_next_y} - {r_work_y[COORD_W-1], r_work_y};
    assign w_t_s    = {1'b0, i_t};
    assign w_prod_x = w_diff_x * w_t_s;
    assign w_prod_y = w_diff_y * w_t_s;

    // Hold the control point; cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_x <= '0;
            r_ctrl_y <= '0;
        end else if (i_wr) begin
            r_ctrl_x <= i_wr_x;
            r_ctrl_y <= i_wr_y;
        end
    end

    // Register the scaled difference, low word of floor(prod / 2^FRAC_BITS)
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod_x <= w_prod_x[FRAC_BITS +: COORD_W];
            r_prod_y <= w_prod_y[FRAC_BITS +: COORD_W];
        end
    end

    // Load or advance the work point
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_work_x <= r_ctrl_x;
            r_work_y <= r_ctrl_y;
        end else if (i_ctrl.acc) begin
            r_work_x <= r_work_x + r_prod_x;
            r_work_y <= r_work_y + r_prod_y;
        end
    end

    assign o_work_x = r_work_x;
    assign o_work_y = r_work_y;

endmodule

// ----- rtl/core/bpdc_checker.sv -----
// ----------------------------------------------------------------------------
// bpdc_checker
// Port-level checks for the Bezier point evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bpdc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  bpdc_pkg::t_in_beat                 i_in_data,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  bpdc_pkg::t_out_beat                o_out_data
);
    import bpdc_pkg::*;

    logic w_in_acc;

    assign w_in_acc = i_in_valid && o_in_ready;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat dropped or changed while stalled");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Reset leaves the block ready for input
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    // A write beat creates no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_data.operation == OP_WRITE) && !o_out_valid)
        |=> !o_out_valid)
        else $error("write beat produced a result");

    // An evaluate beat occupies the block for at least the next cycle
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_data.operation == OP_EVAL)) |=> !o_in_ready)
        else $error("input ready right after an evaluate beat");

endmodule

bind bezier_point_de_casteljau_core bpdc_checker u_bpdc_checker (.*);
